// ===== rtl/fpls_pkg.sv =====
`timescale 1ns / 1ps

package fpls_pkg;

  localparam int DEF_COORD_BITS = 12;
  localparam int DEF_COLOR_BITS = 8;

  // dda accumulator and step widths
  localparam int FRAC_BITS = 16;
  localparam int STEP_BITS = FRAC_BITS + 1;
  localparam int QUO_BITS  = STEP_BITS + 1;
  localparam int CNT_BITS  = $clog2(QUO_BITS);
  localparam logic [FRAC_BITS-1:0] ACC_INIT = 16'h8000;
  localparam logic [CNT_BITS-1:0]  DIV_LAST = CNT_BITS'(QUO_BITS - 1);

  // request codes
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  // program counter
  localparam int PC_BITS = 2;
  localparam logic [PC_BITS-1:0] PC_DISPATCH = 2'd0;
  localparam logic [PC_BITS-1:0] PC_DIVIDE   = 2'd1;
  localparam logic [PC_BITS-1:0] PC_FINISH   = 2'd2;

  // sequencing codes
  localparam logic [1:0] BR_START = 2'd0;  // to target on a start of a line longer than one point, else stay
  localparam logic [1:0] BR_LOOP  = 2'd1;  // back to target while count left
  localparam logic [1:0] BR_OUT   = 2'd2;  // to target once the result slot is free
  localparam logic [1:0] BR_HOLD  = 2'd3;

  typedef struct packed {
    logic               take_in;
    logic               div_step;
    logic               emit_first;
    logic [1:0]         br;
    logic [PC_BITS-1:0] target;
  } ctrl_t;

  function automatic ctrl_t ucode(input logic [PC_BITS-1:0] pc);
    ctrl_t cw;
    cw = '{take_in: 1'b0, div_step: 1'b0, emit_first: 1'b0, br: BR_HOLD,
           target: PC_DISPATCH};
    case (pc)
      PC_DISPATCH: begin
        cw.take_in = 1'b1;
        cw.br      = BR_START;
        cw.target  = PC_DIVIDE;
      end
      PC_DIVIDE: begin
        cw.div_step = 1'b1;
        cw.br       = BR_LOOP;
        cw.target   = PC_DIVIDE;
      end
      PC_FINISH: begin
        cw.emit_first = 1'b1;
        cw.br         = BR_OUT;
        cw.target     = PC_DISPATCH;
      end
      default: begin
        cw.br     = BR_OUT;
        cw.target = PC_DISPATCH;
      end
    endcase
    return cw;
  endfunction

endpackage

// ===== rtl/fixed_point_line_stepper_unit.sv =====
`timescale 1ns / 1ps

// Line pixel pump using a 16-bit fixed-point DDA. A start transaction
// (req_type 0) sorts the endpoints top to bottom, picks the major axis and
// then runs a restoring divider, one quotient bit per cycle, to get the
// rounded minor-axis step; the first pixel comes out after the dispatch,
// divide and finish steps, or in the next cycle for a single-point line.
// Each step transaction (req_type 1) returns the next pixel, so a line
// streams at one pixel per cycle while the output is not stalled. A step
// with no line in progress returns pixel_valid 0 with all other fields
// zero. A start abandons any line in progress. The sequencing comes from
// a three-word control program.
module fixed_point_line_stepper_unit #(
  parameter int COORD_BITS = fpls_pkg::DEF_COORD_BITS,
  parameter int COLOR_BITS = fpls_pkg::DEF_COLOR_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_req_type,
  input  logic [COORD_BITS-1:0] in_x_start,
  input  logic [COORD_BITS-1:0] in_y_start,
  input  logic [COORD_BITS-1:0] in_x_end,
  input  logic [COORD_BITS-1:0] in_y_end,
  input  logic [COLOR_BITS-1:0] in_line_color,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS-1:0] out_pixel_x,
  output logic [COORD_BITS-1:0] out_pixel_y,
  output logic [COLOR_BITS-1:0] out_pixel_color,
  output logic                  out_pixel_valid,
  output logic                  out_last_pixel
);

  import fpls_pkg::*;

  localparam logic [COORD_BITS-1:0] CRD_ONE = COORD_BITS'(1);

  // sequencer
  logic [PC_BITS-1:0]    pc_r, pc_nxt;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;
  ctrl_t                 cw;

  // line state
  logic [COORD_BITS-1:0] cur_x_r, cur_x_nxt;
  logic [COORD_BITS-1:0] cur_y_r, cur_y_nxt;
  logic [COORD_BITS-1:0] steps_left_r, steps_left_nxt;
  logic [STEP_BITS-1:0]  frac_step_r, frac_step_nxt;
  logic [FRAC_BITS-1:0]  err_accum_r, err_accum_nxt;
  logic                  x_step_neg_r, x_step_neg_nxt;
  logic                  y_is_major_r, y_is_major_nxt;
  logic                  busy_r, busy_nxt;
  logic [COLOR_BITS-1:0] held_color_r, held_color_nxt;

  // divider
  logic [COORD_BITS:0]   rem_r, rem_nxt;
  logic [QUO_BITS-1:0]   quo_r, quo_nxt;

  // result register
  logic                  out_valid_r, out_valid_nxt;
  logic [COORD_BITS-1:0] o_x_r, o_x_nxt;
  logic [COORD_BITS-1:0] o_y_r, o_y_nxt;
  logic [COLOR_BITS-1:0] o_color_r, o_color_nxt;
  logic                  o_pv_r, o_pv_nxt;
  logic                  o_last_r, o_last_nxt;

  logic                  out_free;
  logic                  in_take;
  logic                  is_start;

  // start setup
  logic                  swap;
  logic [COORD_BITS-1:0] sx0, sy0, sx1, sy1;
  logic [COORD_BITS-1:0] dx, dy, major, minor;
  logic                  neg, ymaj, single_pt;

  // dda step
  logic [STEP_BITS-1:0]  acc_sum;
  logic                  carry;
  logic [COORD_BITS-1:0] x_adv;
  logic [COORD_BITS-1:0] steps_dec;

  // divide step
  logic [COORD_BITS:0]   div_sub;
  logic                  div_ge;
  logic [COORD_BITS:0]   div_keep;
  logic [QUO_BITS-1:0]   quo_rnd;

  assign cw       = ucode(pc_r);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !(cw.take_in && out_free);
  assign in_take  = in_valid && !in_stall;
  assign is_start = in_req_type == REQ_START;

  always_comb begin
    swap  = in_y_start > in_y_end;
    sx0   = swap ? in_x_end   : in_x_start;
    sy0   = swap ? in_y_end   : in_y_start;
    sx1   = swap ? in_x_start : in_x_end;
    sy1   = swap ? in_y_start : in_y_end;
    neg   = sx1 < sx0;
    dx    = neg ? sx0 - sx1 : sx1 - sx0;
    dy    = sy1 - sy0;
    ymaj  = dy > dx;
    major = ymaj ? dy : dx;
    minor = ymaj ? dx : dy;
    single_pt = (dx == '0) && (dy == '0);
  end

  always_comb begin
    acc_sum   = {1'b0, err_accum_r} + frac_step_r;
    carry     = acc_sum[STEP_BITS-1];
    x_adv     = x_step_neg_r ? cur_x_r - CRD_ONE : cur_x_r + CRD_ONE;
    steps_dec = steps_left_r - CRD_ONE;
  end

  always_comb begin
    div_ge   = rem_r >= {1'b0, steps_left_r};
    div_sub  = rem_r - {1'b0, steps_left_r};
    div_keep = div_ge ? div_sub : rem_r;
    quo_rnd  = quo_r + QUO_BITS'(1);
  end

  always_comb begin
    pc_nxt         = pc_r;
    cnt_nxt        = cnt_r;
    cur_x_nxt      = cur_x_r;
    cur_y_nxt      = cur_y_r;
    steps_left_nxt = steps_left_r;
    frac_step_nxt  = frac_step_r;
    err_accum_nxt  = err_accum_r;
    x_step_neg_nxt = x_step_neg_r;
    y_is_major_nxt = y_is_major_r;
    busy_nxt       = busy_r;
    held_color_nxt = held_color_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    out_valid_nxt  = out_valid_r && out_stall;
    o_x_nxt        = o_x_r;
    o_y_nxt        = o_y_r;
    o_color_nxt    = o_color_r;
    o_pv_nxt       = o_pv_r;
    o_last_nxt     = o_last_r;

    if (in_take) begin
      if (is_start) begin
        cur_x_nxt      = sx0;
        cur_y_nxt      = sy0;
        held_color_nxt = in_line_color;
        x_step_neg_nxt = neg;
        err_accum_nxt  = ACC_INIT;
        if (single_pt) begin
          busy_nxt       = 1'b0;
          steps_left_nxt = '0;
          frac_step_nxt  = '0;
          y_is_major_nxt = 1'b0;
          out_valid_nxt  = 1'b1;
          o_x_nxt        = sx0;
          o_y_nxt        = sy0;
          o_color_nxt    = in_line_color;
          o_pv_nxt       = 1'b1;
          o_last_nxt     = 1'b1;
        end else begin
          busy_nxt       = 1'b1;
          steps_left_nxt = major;
          y_is_major_nxt = ymaj;
          rem_nxt        = {1'b0, minor};
          quo_nxt        = '0;
          cnt_nxt        = DIV_LAST;
        end
      end else if (busy_r) begin
        err_accum_nxt = acc_sum[FRAC_BITS-1:0];
        if (y_is_major_r) begin
          if (carry) cur_x_nxt = x_adv;
          cur_y_nxt = cur_y_r + CRD_ONE;
        end else begin
          if (carry) cur_y_nxt = cur_y_r + CRD_ONE;
          cur_x_nxt = x_adv;
        end
        steps_left_nxt = steps_dec;
        busy_nxt       = steps_dec != '0;
        out_valid_nxt  = 1'b1;
        o_x_nxt        = cur_x_nxt;
        o_y_nxt        = cur_y_nxt;
        o_color_nxt    = held_color_r;
        o_pv_nxt       = 1'b1;
        o_last_nxt     = steps_dec == '0;
      end else begin
        out_valid_nxt = 1'b1;
        o_x_nxt       = '0;
        o_y_nxt       = '0;
        o_color_nxt   = '0;
        o_pv_nxt      = 1'b0;
        o_last_nxt    = 1'b0;
      end
    end

    // one quotient bit per cycle, remainder stays below twice the divisor
    if (cw.div_step) begin
      quo_nxt = {quo_r[QUO_BITS-2:0], div_ge};
      rem_nxt = {div_keep[COORD_BITS-1:0], 1'b0};
      cnt_nxt = cnt_r - CNT_BITS'(1);
    end

    if (cw.emit_first && out_free) begin
      frac_step_nxt = quo_rnd[QUO_BITS-1:1];
      out_valid_nxt = 1'b1;
      o_x_nxt       = cur_x_r;
      o_y_nxt       = cur_y_r;
      o_color_nxt   = held_color_r;
      o_pv_nxt      = 1'b1;
      o_last_nxt    = 1'b0;
    end

    case (cw.br)
      BR_START: if (in_take && is_start && !single_pt) pc_nxt = cw.target;
      BR_LOOP:  pc_nxt = (cnt_r != '0) ? cw.target : pc_r + PC_BITS'(1);
      BR_OUT:   if (out_free) pc_nxt = cw.target;
      default:  pc_nxt = pc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PC_DISPATCH;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      err_accum_r <= ACC_INIT;
    end else begin
      pc_r        <= pc_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      err_accum_r <= err_accum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    cur_x_r      <= cur_x_nxt;
    cur_y_r      <= cur_y_nxt;
    steps_left_r <= steps_left_nxt;
    frac_step_r  <= frac_step_nxt;
    x_step_neg_r <= x_step_neg_nxt;
    y_is_major_r <= y_is_major_nxt;
    held_color_r <= held_color_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    o_x_r        <= o_x_nxt;
    o_y_r        <= o_y_nxt;
    o_color_r    <= o_color_nxt;
    o_pv_r       <= o_pv_nxt;
    o_last_r     <= o_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = o_x_r;
  assign out_pixel_y     = o_y_r;
  assign out_pixel_color = o_color_r;
  assign out_pixel_valid = o_pv_r;
  assign out_last_pixel  = o_last_r;

`ifndef SYNTH
  // last divide iteration hands over to the finish step
  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == PC_DIVIDE && cnt_r == '0) |=> pc_r == PC_FINISH)
    else $error("divider did not exit to finish step");

  // a line in progress always has pixels left while steps are taken
  a_busy_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == PC_DISPATCH && busy_r) |-> steps_left_r != '0)
    else $error("busy with no steps left");

  // the rounded step never exceeds one whole pixel
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == PC_DISPATCH && frac_step_r[STEP_BITS-1]) |-> frac_step_r[FRAC_BITS-1:0] == '0)
    else $error("fractional step above one pixel");

  // an invalid pixel carries only zeros
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !o_pv_r) |-> (o_x_r == '0 && o_y_r == '0 && o_color_r == '0 && !o_last_r))
    else $error("idle step result not cleared");
`endif

endmodule

// ===== tb/sv/fixed_point_line_stepper_unit_test.sv =====
`timescale 1ns / 1ps

module fixed_point_line_stepper_unit_test;

  localparam int CW = fpls_pkg::DEF_COORD_BITS;
  localparam int KW = fpls_pkg::DEF_COLOR_BITS;
  localparam int FW = fpls_pkg::FRAC_BITS;
  localparam int COORD_MAX = (1 << CW) - 1;
  localparam int SHORT_SPREAD = 15;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;

  typedef logic [CW-1:0] coord_t;
  typedef logic [KW-1:0] color_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    color_t color;
    logic   valid;
    logic   last;
  } pixel_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;

  logic   in_valid = 1'b0;
  logic   in_stall;
  logic   in_req_type = fpls_pkg::REQ_STEP;
  coord_t in_x_start = '0;
  coord_t in_y_start = '0;
  coord_t in_x_end = '0;
  coord_t in_y_end = '0;
  color_t in_line_color = '0;

  logic   out_valid;
  logic   out_stall = 1'b0;
  coord_t out_pixel_x;
  coord_t out_pixel_y;
  color_t out_pixel_color;
  logic   out_pixel_valid;
  logic   out_last_pixel;

  // line tracker state
  coord_t        pos_x = '0;
  coord_t        pos_y = '0;
  coord_t        pix_remaining = '0;
  logic [FW:0]   slope_step = '0;
  logic [FW-1:0] dda_acc = fpls_pkg::ACC_INIT;
  logic          x_backward = 1'b0;
  logic          steep = 1'b0;
  logic          line_active = 1'b0;
  color_t        line_color_q = '0;

  pixel_t expected_pixels[$];
  int     error_count = 0;
  int     quiet_cycles = 0;
  int     hold_off_left = 0;
  int     tx_idle_pct = 8;
  int     rx_stall_pct = 50;

  fixed_point_line_stepper_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_x_start      (in_x_start),
    .in_y_start      (in_y_start),
    .in_x_end        (in_x_end),
    .in_y_end        (in_y_end),
    .in_line_color   (in_line_color),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_color (out_pixel_color),
    .out_pixel_valid (out_pixel_valid),
    .out_last_pixel  (out_last_pixel)
  );

  always #10 clk = ~clk;

  function automatic pixel_t next_pixel(logic req, coord_t xs, coord_t ys, coord_t xe,
                                        coord_t ye, color_t c);
    coord_t        x0, y0, x1, y1, dx, dy, major, minor;
    logic [31:0]   quotient;
    logic [FW:0]   acc_sum;
    logic          carry;
    pixel_t        p;
    p = '0;
    if (req == fpls_pkg::REQ_START) begin
      // lines always run top to bottom
      if (ys > ye) begin
        x0 = xe; y0 = ye; x1 = xs; y1 = ys;
      end else begin
        x0 = xs; y0 = ys; x1 = xe; y1 = ye;
      end
      line_color_q = c;
      pos_x = x0;
      pos_y = y0;
      dda_acc = fpls_pkg::ACC_INIT;
      x_backward = x1 < x0;
      dx = x_backward ? x0 - x1 : x1 - x0;
      dy = y1 - y0;
      if (dx == 0 && dy == 0) begin
        line_active = 1'b0;
        pix_remaining = '0;
        slope_step = '0;
        steep = 1'b0;
        p.last = 1'b1;
      end else begin
        steep = dy > dx;
        major = steep ? dy : dx;
        minor = steep ? dx : dy;
        // rounded step with 16 fraction bits
        quotient = (32'(minor) << (FW + 1)) / 32'(major);
        slope_step = (FW + 1)'((quotient + 32'd1) >> 1);
        pix_remaining = major;
        line_active = 1'b1;
      end
      p.x = pos_x;
      p.y = pos_y;
      p.color = line_color_q;
      p.valid = 1'b1;
    end else if (line_active) begin
      acc_sum = {1'b0, dda_acc} + slope_step;
      carry = acc_sum[FW];
      dda_acc = acc_sum[FW-1:0];
      if (steep) begin
        if (carry) pos_x = x_backward ? pos_x - coord_t'(1) : pos_x + coord_t'(1);
        pos_y = pos_y + coord_t'(1);
      end else begin
        if (carry) pos_y = pos_y + coord_t'(1);
        pos_x = x_backward ? pos_x - coord_t'(1) : pos_x + coord_t'(1);
      end
      pix_remaining = pix_remaining - coord_t'(1);
      line_active = pix_remaining != 0;
      p = '{pos_x, pos_y, line_color_q, 1'b1, !line_active};
    end
    return p;
  endfunction

  function automatic coord_t near(coord_t base, int spread);
    int v;
    v = int'(base) + int'($urandom_range(2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return coord_t'(v);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic send_request(logic req, coord_t xs, coord_t ys, coord_t xe, coord_t ye,
                              color_t c);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_x_start <= xs;
    in_y_start <= ys;
    in_x_end <= xe;
    in_y_end <= ye;
    in_line_color <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_pixels.push_back(next_pixel(req, xs, ys, xe, ye, c));
  endtask

  // endpoint and colour fields are don't-care on a step, so fill them with noise
  task automatic send_step();
    send_request(fpls_pkg::REQ_STEP, coord_t'($urandom), coord_t'($urandom),
                 coord_t'($urandom), coord_t'($urandom), color_t'($urandom));
  endtask

  task automatic run_line(coord_t xs, coord_t ys, coord_t xe, coord_t ye, color_t c,
                          int steps);
    send_request(fpls_pkg::REQ_START, xs, ys, xe, ye, c);
    repeat (steps) send_step();
  endtask

  task automatic wait_for_pixels();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic random_line(output int sent);
    coord_t xs, ys;
    int     spread, steps;
    spread = ($urandom_range(9) == 0) ? COORD_MAX : SHORT_SPREAD;
    xs = coord_t'($urandom);
    ys = coord_t'($urandom);
    send_request(fpls_pkg::REQ_START, xs, ys, near(xs, spread), near(ys, spread),
                 color_t'($urandom));
    steps = int'(pix_remaining);
    if (spread != SHORT_SPREAD) begin
      steps = $urandom_range(6);
    end else begin
      case ($urandom_range(7))
        0: steps = $urandom_range(steps);
        1: steps += $urandom_range(2, 1);
        default: ;
      endcase
    end
    repeat (steps) send_step();
    sent = 1 + steps;
  endtask

  task automatic test_directed_lines();
    send_step();
    run_line(0, 0, 0, 0, 8'h00, 0);
    run_line(coord_t'(COORD_MAX), coord_t'(COORD_MAX), coord_t'(COORD_MAX),
             coord_t'(COORD_MAX), 8'hFF, 1);
    run_line(0, 7, 3, 7, 8'hA5, 4);
    run_line(3, coord_t'(COORD_MAX), 3, coord_t'(COORD_MAX - 3), 8'h5A, 3);
    run_line(20, 10, 17, 13, 8'h0F, 3);
    // full-span lines, each abandoned by the next start
    run_line(0, 0, coord_t'(COORD_MAX), coord_t'(COORD_MAX - 1), 8'hF0, 3);
    run_line(coord_t'(COORD_MAX), coord_t'(COORD_MAX), 0, 0, 8'hFF, 2);
    run_line(coord_t'(COORD_MAX), 0, 0, coord_t'(COORD_MAX), 8'h01, 2);
    run_line(9, 9, 9, 9, 8'h80, 1);
    wait_for_pixels();
  endtask

  task automatic test_output_hold_off();
    hold_off_left = 300;
    run_line(100, 200, 140, 210, 8'h3C, 40);
    wait_for_pixels();
  endtask

  task automatic test_random_lines(int tx_pct, int rx_pct, int n_items);
    int n;
    int sent;
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    n = 0;
    while (n < n_items) begin
      if ($urandom_range(11) == 0) begin
        send_step();
        n++;
      end else begin
        random_line(sent);
        n += sent;
      end
    end
    wait_for_pixels();
  endtask

  always @(posedge clk) begin
    if (hold_off_left > 0) begin
      out_stall <= 1'b1;
      hold_off_left <= hold_off_left - 1;
    end else begin
      out_stall <= $urandom_range(99) < rx_stall_pct;
    end
  end

  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("pixel with no transaction pending", 32'(out_pixel_x), 0);
      end else begin
        want = expected_pixels.pop_front();
        if (out_pixel_x !== want.x)
          report_mismatch("pixel_x", 32'(out_pixel_x), 32'(want.x));
        if (out_pixel_y !== want.y)
          report_mismatch("pixel_y", 32'(out_pixel_y), 32'(want.y));
        if (out_pixel_color !== want.color)
          report_mismatch("pixel_color", 32'(out_pixel_color), 32'(want.color));
        if (out_pixel_valid !== want.valid)
          report_mismatch("pixel_valid", 32'(out_pixel_valid), 32'(want.valid));
        if (out_last_pixel !== want.last)
          report_mismatch("last_pixel", 32'(out_last_pixel), 32'(want.last));
      end
    end
  end

  // ends the run if neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_lines();
    test_output_hold_off();
    test_random_lines(8, 50, 125);
    test_random_lines(50, 8, 125);
    test_random_lines(0, 0, 125);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/fpls_pkg.sv
rtl/fixed_point_line_stepper_unit.sv
tb/sv/fixed_point_line_stepper_unit_test.sv
